@@ design/nnrs_pkg.sv @@
// Package for the nearest-neighbor BMP row scaler.
// Holds the state, register index, config and command/status types shared by all modules.
// No dependencies.
package nnrs_pkg;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam int PIX_W  = 8;
	localparam int REG_SZ_W = 13;
	localparam int FCT_W  = 5;
	localparam logic [PIX_W-1:0] PAD_BYTE = 8'h00;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PIXEL,
		ST_PAD
	} nnrs_state_t;

	typedef enum logic [1:0] {
		REG_MODE,
		REG_FACTOR,
		REG_WIDTH,
		REG_HEIGHT
	} nnrs_reg_t;

	typedef enum logic [1:0] {
		CMP_BLUE,
		CMP_GREEN,
		CMP_RED,
		CMP_NONE
	} nnrs_comp_t;

	typedef struct packed {
		logic                reduce;
		logic [FCT_W-1:0]    factor;
		logic [REG_SZ_W-1:0] width;
		logic [REG_SZ_W-1:0] height;
	} nnrs_cfg_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic pad;
		logic final_byte;
	} nnrs_cmd_t;

	typedef struct packed {
		logic emit;
		logic pix_done;
		logic pad_any;
		logic pad_done;
		logic out_free;
	} nnrs_stat_t;

endpackage

@@ design/nnrs_if.sv @@
// Handshake interfaces for the nearest-neighbor BMP row scaler.
// nnrs_pix_if carries source pixels, nnrs_byte_if carries output image bytes; no dependencies.
interface nnrs_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pix_blue;
	logic [7:0] pix_green;
	logic [7:0] pix_red;

	modport source (output valid, output pix_blue, output pix_green, output pix_red,
		input ready);
	modport sink (input valid, input pix_blue, input pix_green, input pix_red,
		output ready);
endinterface

interface nnrs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       row_done;
	logic       frame_done;

	modport source (output valid, output out_byte, output run_last, output row_done,
		output frame_done, input ready);
	modport sink (input valid, input out_byte, input run_last, input row_done,
		input frame_done, output ready);
endinterface

@@ design/nnrs_cfg.sv @@
// APB register bank of the nearest-neighbor BMP row scaler.
// Holds mode, factor, width and height; pulses clear on every write. Uses nnrs_pkg.
module nnrs_cfg
	import nnrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output nnrs_cfg_t         cfg,
	output logic              clear
);

	nnrs_cfg_t cfg_q;
	nnrs_reg_t reg_sel;
	logic      wr_en;

	assign pready  = 1'b1;
	assign reg_sel = nnrs_reg_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign clear   = wr_en;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reduce <= 1'b0;
			cfg_q.factor <= FCT_W'(1);
			cfg_q.width  <= REG_SZ_W'(1);
			cfg_q.height <= REG_SZ_W'(1);
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_MODE:   cfg_q.reduce <= pwdata[0];
				REG_FACTOR: cfg_q.factor <= pwdata[FCT_W-1:0];
				REG_WIDTH:  cfg_q.width  <= pwdata[REG_SZ_W-1:0];
				REG_HEIGHT: cfg_q.height <= pwdata[REG_SZ_W-1:0];
				default:    cfg_q.reduce <= cfg_q.reduce;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MODE:   prdata = APB_DW'(cfg_q.reduce);
			REG_FACTOR: prdata = APB_DW'(cfg_q.factor);
			REG_WIDTH:  prdata = APB_DW'(cfg_q.width);
			REG_HEIGHT: prdata = APB_DW'(cfg_q.height);
			default:    prdata = '0;
		endcase
	end

endmodule

@@ design/nnrs_ctrl.sv @@
// Controller of the nearest-neighbor BMP row scaler.
// Sequences pixel bytes and row padding and issues commands to nnrs_dp. Uses nnrs_pkg.
module nnrs_ctrl
	import nnrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  nnrs_stat_t stat,
	output nnrs_cmd_t  cmd
);

	nnrs_state_t state_q;
	nnrs_state_t state_d;
	logic        next_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign next_pixel = in_valid && stat.emit;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (next_pixel)
					state_d = ST_PIXEL;
			end
			ST_PIXEL: begin
				if (cmd.load && stat.pix_done) begin
					if (stat.pad_any)
						state_d = ST_PAD;
					else
						state_d = next_pixel ? ST_PIXEL : ST_IDLE;
				end
			end
			ST_PAD: begin
				if (cmd.load && stat.pad_done)
					state_d = next_pixel ? ST_PIXEL : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = 1'b0;
			end
			ST_PIXEL: begin
				cmd.load       = stat.out_free;
				cmd.final_byte = stat.out_free && stat.pix_done && !stat.pad_any;
			end
			ST_PAD: begin
				cmd.load       = stat.out_free;
				cmd.pad        = 1'b1;
				cmd.final_byte = stat.out_free && stat.pad_done;
			end
			default: cmd.load = 1'b0;
		endcase
		in_ready   = (state_q == ST_IDLE) || cmd.final_byte;
		cmd.accept = in_valid && in_ready;
	end

endmodule

@@ design/nnrs_dp.sv @@
// Datapath of the nearest-neighbor BMP row scaler.
// Holds position counters, the per-pixel plan, byte counters and the output register.
// Uses nnrs_pkg and nnrs_byte_if; driven by commands from nnrs_ctrl.
module nnrs_dp
	import nnrs_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_FACTOR = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nnrs_cfg_t          cfg,
	input  logic               clear,
	input  nnrs_cmd_t          cmd,
	output nnrs_stat_t         stat,
	input  logic [PIX_W-1:0]   pix_blue,
	input  logic [PIX_W-1:0]   pix_green,
	input  logic [PIX_W-1:0]   pix_red,
	nnrs_byte_if.source        byte_out
);

	localparam int PW = $clog2(MAX_FACTOR);
	localparam int FW = $clog2(MAX_FACTOR + 1);
	localparam int CW = ($clog2(MAX_WIDTH) < REG_SZ_W) ? $clog2(MAX_WIDTH) : REG_SZ_W;
	localparam int SW = REG_SZ_W + 1;

	logic [FCT_W-1:0]    f5;
	logic [FW-1:0]       f_eff;
	logic [PW-1:0]       f_m1;
	logic [REG_SZ_W-1:0] w_eff;
	logic [REG_SZ_W-1:0] h_eff;
	logic [REG_SZ_W-1:0] w_m1;
	logic [REG_SZ_W-1:0] h_m1;

	logic [CW-1:0]       col_q;
	logic [REG_SZ_W-1:0] row_q;
	logic [PW-1:0]       cph_q;
	logic [PW-1:0]       rph_q;
	logic [1:0]          opx_q;

	logic [PIX_W-1:0]    blue_q;
	logic [PIX_W-1:0]    green_q;
	logic [PIX_W-1:0]    red_q;
	logic                row_end_q;
	logic                frame_end_q;
	logic [1:0]          pad_n_q;
	logic [PW-1:0]       last_rep_q;

	nnrs_comp_t          comp_q;
	logic [PW-1:0]       rep_q;
	logic [1:0]          pad_cnt_q;

	logic                out_valid_q;
	logic [PIX_W-1:0]    out_byte_q;
	logic                run_last_q;
	logic                row_done_q;
	logic                frame_done_q;

	logic [SW-1:0]       c_f;
	logic [SW-1:0]       c_2f;
	logic [SW-1:0]       r_f;
	logic [SW-1:0]       r_2f;
	logic                col_last;
	logic                row_last;
	logic                p_emit;
	logic                p_row_end;
	logic                p_frame_end;
	logic [1:0]          p_pad;
	logic [PIX_W-1:0]    pix_byte;

	always_comb begin
		if (cfg.factor == '0)
			f5 = FCT_W'(1);
		else if (cfg.factor > FCT_W'(MAX_FACTOR))
			f5 = FCT_W'(MAX_FACTOR);
		else
			f5 = cfg.factor;
		f_eff = FW'(f5);
		f_m1  = PW'(f5 - FCT_W'(1));
		if (cfg.width == '0)
			w_eff = REG_SZ_W'(1);
		else if (32'(cfg.width) > MAX_WIDTH)
			w_eff = REG_SZ_W'(MAX_WIDTH);
		else
			w_eff = cfg.width;
		h_eff = (cfg.height == '0) ? REG_SZ_W'(1) : cfg.height;
		w_m1  = w_eff - REG_SZ_W'(1);
		h_m1  = h_eff - REG_SZ_W'(1);
	end

	always_comb begin
		c_f      = SW'(col_q) + SW'(f_eff);
		c_2f     = c_f + SW'(f_eff);
		r_f      = SW'(row_q) + SW'(f_eff);
		r_2f     = r_f + SW'(f_eff);
		col_last = (REG_SZ_W'(col_q) == w_m1);
		row_last = (row_q == h_m1);
		if (!cfg.reduce) begin
			p_emit      = 1'b1;
			p_row_end   = col_last;
			p_frame_end = col_last && row_last && (rph_q == f_m1);
			p_pad       = opx_q + f_eff[1:0];
		end else begin
			p_emit      = (cph_q == '0) && (rph_q == '0) && (c_f <= SW'(w_eff))
				&& (r_f <= SW'(h_eff));
			p_row_end   = p_emit && (c_2f > SW'(w_eff));
			p_frame_end = p_row_end && (r_2f > SW'(h_eff));
			p_pad       = opx_q + 2'd1;
		end
	end

	// advance position counters on every accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cph_q <= '0;
			rph_q <= '0;
			opx_q <= '0;
		end else if (clear) begin
			col_q <= '0;
			row_q <= '0;
			cph_q <= '0;
			rph_q <= '0;
			opx_q <= '0;
		end else if (cmd.accept) begin
			if (!cfg.reduce) begin
				if (col_last) begin
					col_q <= '0;
					opx_q <= '0;
					if (rph_q == f_m1) begin
						rph_q <= '0;
						row_q <= row_last ? '0 : row_q + REG_SZ_W'(1);
					end else begin
						rph_q <= rph_q + PW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
					opx_q <= opx_q + f_eff[1:0];
				end
			end else begin
				if (p_emit)
					opx_q <= p_row_end ? 2'd0 : opx_q + 2'd1;
				if (col_last) begin
					col_q <= '0;
					cph_q <= '0;
					if (row_last) begin
						row_q <= '0;
						rph_q <= '0;
					end else begin
						row_q <= row_q + REG_SZ_W'(1);
						rph_q <= (rph_q == f_m1) ? '0 : rph_q + PW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
					cph_q <= (cph_q == f_m1) ? '0 : cph_q + PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			blue_q      <= pix_blue;
			green_q     <= pix_green;
			red_q       <= pix_red;
			row_end_q   <= p_row_end;
			frame_end_q <= p_frame_end;
			pad_n_q     <= p_pad;
			last_rep_q  <= cfg.reduce ? '0 : f_m1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q    <= CMP_BLUE;
			rep_q     <= '0;
			pad_cnt_q <= '0;
		end else if (cmd.accept) begin
			comp_q    <= CMP_BLUE;
			rep_q     <= '0;
			pad_cnt_q <= '0;
		end else if (cmd.load) begin
			if (cmd.pad) begin
				pad_cnt_q <= pad_cnt_q + 2'd1;
			end else if (comp_q == CMP_RED) begin
				comp_q <= CMP_BLUE;
				rep_q  <= rep_q + PW'(1);
			end else begin
				comp_q <= nnrs_comp_t'(comp_q + 2'd1);
			end
		end
	end

	always_comb begin
		case (comp_q)
			CMP_BLUE:  pix_byte = blue_q;
			CMP_GREEN: pix_byte = green_q;
			CMP_RED:   pix_byte = red_q;
			default:   pix_byte = PAD_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (byte_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q   <= cmd.pad ? PAD_BYTE : pix_byte;
			run_last_q   <= cmd.final_byte;
			row_done_q   <= cmd.final_byte && row_end_q;
			frame_done_q <= cmd.final_byte && frame_end_q;
		end
	end

	assign stat.emit     = p_emit;
	assign stat.pix_done = (comp_q == CMP_RED) && (rep_q == last_rep_q);
	assign stat.pad_any  = row_end_q && (pad_n_q != 2'd0);
	assign stat.pad_done = (pad_cnt_q == pad_n_q - 2'd1);
	assign stat.out_free = !out_valid_q || byte_out.ready;

	assign byte_out.valid      = out_valid_q;
	assign byte_out.out_byte   = out_byte_q;
	assign byte_out.run_last   = run_last_q;
	assign byte_out.row_done   = row_done_q;
	assign byte_out.frame_done = frame_done_q;

endmodule

@@ design/nearest_neighbor_bmp_row_scaler.sv @@
// Top level of the nearest-neighbor BMP row scaler.
// Instantiates nnrs_cfg, nnrs_ctrl and nnrs_dp; uses nnrs_pkg, nnrs_pix_if, nnrs_byte_if.
//
// pix_in takes one source pixel per transaction; byte_out gives one BMP byte per
// transaction (blue, green, red, then zero padding to a multiple of four bytes at
// each output row end), flagged with run_last, row_done and frame_done.
// Registers sit on the APB port: mode at 0x0, factor at 0x4, width at 0x8, height
// at 0xC. Any write restarts the frame; write only while the block is idle.
// Each accepted pixel is captured in the pixel registers. A pixel that produces bytes
// gives its blue, green and red bytes f times in enlarge mode (once in reduce mode),
// plus the padding bytes at a row end: the output register moves one byte a cycle while
// byte_out does not stall, and the next pixel is taken together with the last byte of
// the current one. A pixel dropped in reduce mode gives no bytes.
// Reset clears the position counters, loads mode 0, factor 1, width 1 and height 1,
// and empties the output register. When byte_out stalls, the output register holds
// its byte and the sequencer waits; pix_in is ready while the block is idle and in
// the cycle that loads the last byte of the current pixel.
module nearest_neighbor_bmp_row_scaler
	import nnrs_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_FACTOR = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	nnrs_pix_if.sink          pix_in,
	nnrs_byte_if.source       byte_out
);

	nnrs_cfg_t  cfg;
	logic       clear;
	nnrs_cmd_t  cmd;
	nnrs_stat_t stat;
	logic       in_ready;

	nnrs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.clear   (clear)
	);

	nnrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	nnrs_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.clear     (clear),
		.cmd       (cmd),
		.stat      (stat),
		.pix_blue  (pix_in.pix_blue),
		.pix_green (pix_in.pix_green),
		.pix_red   (pix_in.pix_red),
		.byte_out  (byte_out)
	);

	assign pix_in.ready = in_ready;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> stat.out_free)
		else $error("byte loaded over an untaken output byte");

	a_frame_flags: assert property (@(posedge clk) disable iff (!arst_n)
		byte_out.valid && byte_out.frame_done |-> byte_out.row_done && byte_out.run_last)
		else $error("frame end without row end and run end");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && cmd.pad |=> byte_out.valid && (byte_out.out_byte == PAD_BYTE))
		else $error("padding byte is not zero");

	a_busy_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && cmd.load |-> cmd.final_byte)
		else $error("pixel taken before the current one finished");

endmodule

@@ tb/nearest_neighbor_bmp_row_scaler_checker.sv @@
// Checker for the nearest-neighbor BMP row scaler: snoops register writes and both
// channels, predicts the output byte stream of every pixel and compares it in order.
// Depends on nnrs_pkg and the nnrs_pix_if / nnrs_byte_if interfaces.
module nearest_neighbor_bmp_row_scaler_checker
	import nnrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic              pready,
	nnrs_pix_if               pix_ch,
	nnrs_byte_if              byte_ch,
	output int unsigned       pending,
	output int unsigned       fail_count
);

	localparam int unsigned FACTOR_CAP = 16;
	localparam int unsigned WIDTH_CAP  = 4096;

	typedef struct packed {
		logic [PIX_W-1:0] data;
		logic             run_last;
		logic             row_done;
		logic             frame_done;
	} bmp_byte_t;

	logic                cfg_reduce;
	logic [FCT_W-1:0]    cfg_factor;
	logic [REG_SZ_W-1:0] cfg_width;
	logic [REG_SZ_W-1:0] cfg_height;

	int unsigned col_pos;
	int unsigned row_pos;
	int unsigned col_mod;
	int unsigned row_mod;

	bmp_byte_t   pixel_run[$];
	bmp_byte_t   expected_bytes[$];
	int unsigned byte_errors;

	function void emit_byte(logic [PIX_W-1:0] data);
		bmp_byte_t e;
		e = '0;
		e.data = data;
		pixel_run.push_back(e);
	endfunction

	function void emit_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g, logic [PIX_W-1:0] r);
		emit_byte(b);
		emit_byte(g);
		emit_byte(r);
	endfunction

	function void close_row(int unsigned out_width, bit frame_end);
		repeat (out_width & 3) emit_byte(PAD_BYTE);
		if (pixel_run.size() > 0) begin
			pixel_run[pixel_run.size()-1].row_done = 1'b1;
			if (frame_end)
				pixel_run[pixel_run.size()-1].frame_done = 1'b1;
		end
	endfunction

	function void scale_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g, logic [PIX_W-1:0] r);
		int unsigned f, w, h, ow, oh;
		f = (cfg_factor == 0) ? 1 :
			((32'(cfg_factor) > FACTOR_CAP) ? FACTOR_CAP : 32'(cfg_factor));
		w = (cfg_width == 0) ? 1 :
			((32'(cfg_width) > WIDTH_CAP) ? WIDTH_CAP : 32'(cfg_width));
		h = (cfg_height == 0) ? 1 : 32'(cfg_height);
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		if (!cfg_reduce) begin
			if (row_mod >= f) row_mod = 0;
			col_mod = 0;
			repeat (f) emit_pixel(b, g, r);
			if (col_pos == w - 1) begin
				close_row(w * f, (row_pos == h - 1) && (row_mod == f - 1));
				col_pos = 0;
				row_mod++;
				if (row_mod >= f) begin
					row_mod = 0;
					row_pos++;
					if (row_pos >= h) row_pos = 0;
				end
			end else begin
				col_pos++;
			end
		end else begin
			ow = w / f;
			oh = h / f;
			if (col_mod >= f) col_mod = 0;
			if (row_mod >= f) row_mod = 0;
			if (col_mod == 0 && row_mod == 0 && col_pos < ow * f && row_pos < oh * f) begin
				emit_pixel(b, g, r);
				if (col_pos == (ow - 1) * f)
					close_row(ow, row_pos == (oh - 1) * f);
			end
			col_pos++;
			col_mod++;
			if (col_mod >= f) col_mod = 0;
			if (col_pos >= w) begin
				col_pos = 0;
				col_mod = 0;
				row_pos++;
				row_mod++;
				if (row_mod >= f) row_mod = 0;
				if (row_pos >= h) begin
					row_pos = 0;
					row_mod = 0;
				end
			end
		end
		if (pixel_run.size() > 0)
			pixel_run[pixel_run.size()-1].run_last = 1'b1;
		foreach (pixel_run[i])
			expected_bytes.push_back(pixel_run[i]);
		pixel_run.delete();
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		bmp_byte_t got, want;
		if (!arst_n) begin
			cfg_reduce = 1'b0;
			cfg_factor = FCT_W'(1);
			cfg_width = REG_SZ_W'(1);
			cfg_height = REG_SZ_W'(1);
			col_pos = 0;
			row_pos = 0;
			col_mod = 0;
			row_mod = 0;
			expected_bytes.delete();
			byte_errors = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (nnrs_reg_t'(paddr[3:2]))
					REG_MODE:   cfg_reduce = pwdata[0];
					REG_FACTOR: cfg_factor = pwdata[FCT_W-1:0];
					REG_WIDTH:  cfg_width = pwdata[REG_SZ_W-1:0];
					REG_HEIGHT: cfg_height = pwdata[REG_SZ_W-1:0];
				endcase
				col_pos = 0;
				row_pos = 0;
				col_mod = 0;
				row_mod = 0;
			end
			if (pix_ch.valid && pix_ch.ready)
				scale_pixel(pix_ch.pix_blue, pix_ch.pix_green, pix_ch.pix_red);
			if (byte_ch.valid && byte_ch.ready) begin
				got.data = byte_ch.out_byte;
				got.run_last = byte_ch.run_last;
				got.row_done = byte_ch.row_done;
				got.frame_done = byte_ch.frame_done;
				if (expected_bytes.size() == 0) begin
					if (byte_errors < 10)
						$display("unexpected output byte: data %h flags %b%b%b",
							got.data, got.run_last, got.row_done, got.frame_done);
					byte_errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (got !== want) begin
						if (byte_errors < 10)
							$display("byte mismatch: expected %h %b%b%b, got %h %b%b%b",
								want.data, want.run_last, want.row_done, want.frame_done,
								got.data, got.run_last, got.row_done, got.frame_done);
						byte_errors++;
					end
				end
			end
			pending <= expected_bytes.size();
			fail_count <= byte_errors + expected_bytes.size();
		end
	end

endmodule

@@ tb/nearest_neighbor_bmp_row_scaler_tb.sv @@
// Testbench top for the nearest-neighbor BMP row scaler: clock, reset, APB register
// writes, pixel stimulus and output back-pressure; the checker judges the bytes.
// Depends on nnrs_pkg, nnrs_if.sv, the scaler RTL and nearest_neighbor_bmp_row_scaler_checker.
module nearest_neighbor_bmp_row_scaler_tb;
	import nnrs_pkg::*;

	localparam int unsigned SETTLE       = 8;
	localparam int unsigned DRAIN        = 16;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned RANDOM_ITEMS = 280;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	nnrs_pix_if  pix_if();
	nnrs_byte_if byte_if();

	int unsigned pending;
	int unsigned fail_count;
	bit          calm;
	int unsigned pattern_idx;

	logic                sh_mode;
	logic [FCT_W-1:0]    sh_factor;
	logic [REG_SZ_W-1:0] sh_width;
	logic [REG_SZ_W-1:0] sh_height;

	nearest_neighbor_bmp_row_scaler u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.pix_in   (pix_if),
		.byte_out (byte_if)
	);

	nearest_neighbor_bmp_row_scaler_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.pix_ch     (pix_if),
		.byte_ch    (byte_if),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] pattern(int unsigned i);
		case (i % 6)
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'hA5;
			3: return 8'h5A;
			4: return 8'h01;
			default: return 8'h80;
		endcase
	endfunction

	task automatic write_reg(input nnrs_reg_t idx, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic mode, input logic [FCT_W-1:0] factor,
		input logic [REG_SZ_W-1:0] width, input logic [REG_SZ_W-1:0] height,
		input logic [3:0] mask);
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
		if (mask[REG_MODE]) begin
			write_reg(REG_MODE, APB_DW'(mode));
			sh_mode = mode;
		end
		if (mask[REG_FACTOR]) begin
			write_reg(REG_FACTOR, APB_DW'(factor));
			sh_factor = factor;
		end
		if (mask[REG_WIDTH]) begin
			write_reg(REG_WIDTH, APB_DW'(width));
			sh_width = width;
		end
		if (mask[REG_HEIGHT]) begin
			write_reg(REG_HEIGHT, APB_DW'(height));
			sh_height = height;
		end
	endtask

	task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.pix_blue <= b;
		pix_if.pix_green <= g;
		pix_if.pix_red <= r;
		do @(posedge clk); while (!pix_if.ready);
	endtask

	task automatic send_run(input int unsigned count, input bit directed);
		logic [7:0] b, g, r;
		for (int unsigned i = 0; i < count; i++) begin
			if (directed) begin
				b = pattern(pattern_idx);
				g = pattern(pattern_idx + 2);
				r = pattern(pattern_idx + 4);
				pattern_idx++;
			end else begin
				b = 8'($urandom_range(0, 255));
				g = 8'($urandom_range(0, 255));
				r = 8'($urandom_range(0, 255));
			end
			send_pixel(b, g, r);
		end
		pix_if.valid <= 1'b0;
	endtask

	initial begin : output_stall
		int unsigned stall;
		byte_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 14);
			if (stall != 0) begin
				byte_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			byte_if.ready <= 1'b1;
			do @(posedge clk); while (!byte_if.valid);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((pix_if.valid && pix_if.ready) || (byte_if.valid && byte_if.ready) ||
				(psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("** nearest_neighbor_bmp_row_scaler: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int unsigned random_sent, count, frame_len, ef, ew, eh;
		logic                mode;
		logic [FCT_W-1:0]    factor;
		logic [REG_SZ_W-1:0] width, height;
		logic [3:0]          mask;

		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix_if.valid <= 1'b0;
		pix_if.pix_blue <= '0;
		pix_if.pix_green <= '0;
		pix_if.pix_red <= '0;
		calm = 1'b0;
		pattern_idx = 0;
		sh_mode = 1'b0;
		sh_factor = FCT_W'(1);
		sh_width = REG_SZ_W'(1);
		sh_height = REG_SZ_W'(1);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_run(2, 1'b1);
		configure(1'b0, 5'd0, 13'd0, 13'd0, 4'hF);
		send_run(1, 1'b1);
		configure(1'b0, 5'd31, 13'd3, 13'd1, 4'hF);
		send_run(3, 1'b1);
		configure(1'b0, 5'd15, 13'd1, 13'd1, 4'hF);
		send_run(1, 1'b1);
		configure(1'b0, 5'd1, 13'd8191, 13'd1, 4'hF);
		send_run(3, 1'b1);
		configure(1'b1, 5'd4, 13'd3, 13'd5, 4'hF);
		send_run(4, 1'b1);
		configure(1'b1, 5'd2, 13'd3, 13'd2, 4'hF);
		send_run(6, 1'b1);
		configure(1'b0, 5'd2, 13'd2, 13'd1, 4'hF);
		send_run(4, 1'b1);

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			mode = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0: factor = FCT_W'($urandom_range(17, 31));
				1: factor = '0;
				2: factor = FCT_W'(16);
				default: factor = FCT_W'($urandom_range(1, 4));
			endcase
			ef = (factor == 0) ? 1 : ((32'(factor) > 16) ? 16 : 32'(factor));
			case ($urandom_range(0, 11))
				0: width = '0;
				1: width = REG_SZ_W'(4096);
				2: width = REG_SZ_W'($urandom_range(4097, 8191));
				default: width = REG_SZ_W'(mode ? $urandom_range(1, 4 * ef + 3) :
					$urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 11))
				0: height = '0;
				1: height = REG_SZ_W'($urandom_range(4096, 8191));
				default: height = REG_SZ_W'(mode ? $urandom_range(1, 2 * ef + 1) :
					$urandom_range(1, 3));
			endcase
			mask = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(1, 15)) : 4'hF;
			configure(mode, factor, width, height, mask);
			calm = ($urandom_range(0, 3) == 0);
			ef = (sh_factor == 0) ? 1 : ((32'(sh_factor) > 16) ? 16 : 32'(sh_factor));
			ew = (sh_width == 0) ? 1 : ((32'(sh_width) > 4096) ? 4096 : 32'(sh_width));
			eh = (sh_height == 0) ? 1 : 32'(sh_height);
			frame_len = sh_mode ? ew * eh : ew * eh * ef;
			if (frame_len <= 64)
				count = frame_len * $urandom_range(1, 2) +
					(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
			else
				count = $urandom_range(6, 30);
			send_run(count, 1'b0);
			random_sent += count;
		end

		calm = 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0)
			$display("** nearest_neighbor_bmp_row_scaler: PASSED **");
		else
			$display("** nearest_neighbor_bmp_row_scaler: FAILED **");
		$finish;
	end

endmodule
